// ===== rtl/core/voq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voq_pkg: shared types and constants of the vertex quantizer
// Beat layouts, register indexes, pipeline geometry and divider widths.
// ----------------------------------------------------------------------------
package voq_pkg;

  // Five linear lanes: pos x/y/z, tex u/v
  localparam int unsigned NumLin   = 5;
  // Two direction lanes: normal, tangent
  localparam int unsigned NumDir   = 2;

  // Divider geometry: two quotient bits per stage
  localparam int unsigned QuoW     = 16;
  localparam int unsigned DivSteps = QuoW / 2;
  localparam int unsigned NumW     = 34;
  localparam int unsigned DenW     = 18;
  localparam int unsigned L1W      = 17;

  // Pipeline: three prep stages, then the divider stages
  localparam int unsigned NumStg   = DivSteps + 3;

  localparam logic [15:0] QMax        = 16'hFFFF;
  localparam logic [31:0] PosScaleRst = 32'd32768;
  localparam logic [63:0] TexScaleRst = 64'h0000_8000_0000_8000;

  // Replacement directions for an all-zero vector, Q2.14
  localparam logic signed [15:0] DirOne    = 16'sd16384;
  localparam logic signed [15:0] DirNegOne = -16'sd16384;

  typedef enum logic [2:0] {
    REG_POS_CENTER_X = 3'd0,
    REG_POS_CENTER_Y = 3'd1,
    REG_POS_CENTER_Z = 3'd2,
    REG_POS_SCALE_X  = 3'd3,
    REG_POS_SCALE_Y  = 3'd4,
    REG_POS_SCALE_Z  = 3'd5,
    REG_TEX_CENTER   = 3'd6,
    REG_TEX_SCALE    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic               tangent_w_positive;
  } vtx_in_t;

  typedef struct packed {
    logic [15:0] qpos_x;
    logic [15:0] qpos_y;
    logic [15:0] qpos_z;
    logic [15:0] qtex_u;
    logic [15:0] qtex_v;
    logic [15:0] qnormal_a;
    logic [15:0] qnormal_b;
    logic [15:0] qtangent_a;
    logic [15:0] qtangent_b;
    logic        tangent_sign;
  } vtx_out_t;

endpackage

// ===== rtl/core/voq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voq_div: pipelined restoring divider
// Resolves two quotient bits per stage; numerator must be below den * 2^16.
// ----------------------------------------------------------------------------
module voq_div
  import voq_pkg::*;
(
  input  logic                clk_i,
  input  logic [DivSteps-1:0] en_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output logic [QuoW-1:0]     quo_o
);

  logic [NumW-1:0] rem_q [DivSteps];
  logic [DenW-1:0] den_q [DivSteps];
  logic [QuoW-1:0] quo_q [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    localparam int unsigned ShHi = QuoW - 1 - 2 * j;
    localparam int unsigned ShLo = ShHi - 1;

    logic [NumW-1:0] rem_in, rem_mid, rem_d, t_hi, t_lo;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in, quo_d;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign t_hi = NumW'(den_in) << ShHi;
    assign t_lo = NumW'(den_in) << ShLo;

    // Try subtracting the shifted divisor twice
    always_comb begin
      quo_d   = quo_in;
      rem_mid = rem_in;
      if (rem_in >= t_hi) begin
        rem_mid     = rem_in - t_hi;
        quo_d[ShHi] = 1'b1;
      end
      rem_d = rem_mid;
      if (rem_mid >= t_lo) begin
        rem_d       = rem_mid - t_lo;
        quo_d[ShLo] = 1'b1;
      end
    end

    // Advance when the stage is allowed to move
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_in;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[DivSteps-1];

endmodule

// ===== rtl/core/vertex_octahedral_quantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_octahedral_quantizer: 16-bit vertex compression
// Throughput: one vertex per cycle while the output is not stalled; the
// depth is set by the eight-stage divider (two quotient bits per stage)
// of the octahedral mapping.
// Reset clears all valid bits and loads the register reset values;
// no result beat is shown until a vertex is accepted after reset.
// ----------------------------------------------------------------------------
module vertex_octahedral_quantizer
  import voq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vtx_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vtx_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned DlyN = NumStg - 3;

  // Configuration registers
  logic [31:0] pos_center_q [3];
  logic [31:0] pos_scale_q  [3];
  logic [63:0] tex_center_q, tex_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_center_q[i] <= '0;
        pos_scale_q[i]  <= PosScaleRst;
      end
      tex_center_q <= '0;
      tex_scale_q  <= TexScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_POS_CENTER_X: pos_center_q[0] <= cfg_data_i[31:0];
        REG_POS_CENTER_Y: pos_center_q[1] <= cfg_data_i[31:0];
        REG_POS_CENTER_Z: pos_center_q[2] <= cfg_data_i[31:0];
        REG_POS_SCALE_X:  pos_scale_q[0]  <= cfg_data_i[31:0];
        REG_POS_SCALE_Y:  pos_scale_q[1]  <= cfg_data_i[31:0];
        REG_POS_SCALE_Z:  pos_scale_q[2]  <= cfg_data_i[31:0];
        REG_TEX_CENTER:   tex_center_q    <= cfg_data_i;
        REG_TEX_SCALE:    tex_scale_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when empty or when the next one moves
  logic [NumStg-1:0] vld_q;
  logic [NumStg:0]   stg_en;

  always_comb begin
    stg_en[NumStg] = out_ready_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      stg_en[k] = ~vld_q[k] | stg_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStg; k++) begin
        if (stg_en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = stg_en[0];
  assign out_valid_o = vld_q[NumStg-1];

  // ---------------- linear lanes ----------------
  logic [31:0] lin_val [NumLin];
  logic [31:0] lin_ctr [NumLin];
  logic [31:0] lin_scl [NumLin];

  always_comb begin
    lin_val[0] = in_data_i.pos_x;
    lin_val[1] = in_data_i.pos_y;
    lin_val[2] = in_data_i.pos_z;
    lin_val[3] = in_data_i.tex_u;
    lin_val[4] = in_data_i.tex_v;
    for (int i = 0; i < 3; i++) begin
      lin_ctr[i] = pos_center_q[i];
      lin_scl[i] = pos_scale_q[i];
    end
    lin_ctr[3] = tex_center_q[63:32];
    lin_ctr[4] = tex_center_q[31:0];
    lin_scl[3] = tex_scale_q[63:32];
    lin_scl[4] = tex_scale_q[31:0];
  end

  logic        neg0_q [NumLin];
  logic [32:0] mag0_q [NumLin];
  logic [31:0] scl0_q [NumLin];
  logic        neg1_q [NumLin];
  logic [63:0] prod1_q[NumLin];
  logic [32:0] v2_q   [NumLin];
  logic [15:0] lq_q   [DlyN][NumLin];

  logic [32:0] lin_d   [NumLin];
  logic [64:0] lin_prod[NumLin];
  logic [32:0] lin_v   [NumLin];
  logic [47:0] lin_q   [NumLin];

  always_comb begin
    for (int i = 0; i < NumLin; i++) begin
      lin_d[i]    = {lin_val[i][31], lin_val[i]} - {lin_ctr[i][31], lin_ctr[i]};
      lin_prod[i] = 65'(mag0_q[i]) * 65'(scl0_q[i]);
      // Saturate once the offset reaches one half
      if (|prod1_q[i][63:31]) begin
        lin_v[i] = neg1_q[i] ? 33'd0 : 33'h1_0000_0000;
      end else if (neg1_q[i]) begin
        lin_v[i] = 33'h0_8000_0000 - 33'(prod1_q[i][30:0]);
      end else begin
        lin_v[i] = 33'h0_8000_0000 + 33'(prod1_q[i][30:0]);
      end
      // floor(65535 * v / 2^32)
      lin_q[i] = {v2_q[i][31:0], 16'h0000} - 48'(v2_q[i][31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumLin; i++) begin
      if (stg_en[0]) begin
        neg0_q[i] <= lin_d[i][32];
        mag0_q[i] <= lin_d[i][32] ? 33'(-lin_d[i]) : lin_d[i];
        scl0_q[i] <= lin_scl[i];
      end
      if (stg_en[1]) begin
        neg1_q[i]  <= neg0_q[i];
        prod1_q[i] <= lin_prod[i][63:0];
      end
      if (stg_en[2]) v2_q[i] <= lin_v[i];
      if (stg_en[3]) lq_q[0][i] <= v2_q[i][32] ? QMax : lin_q[i][47:32];
      for (int k = 1; k < DlyN; k++) begin
        if (stg_en[k+3]) lq_q[k][i] <= lq_q[k-1][i];
      end
    end
  end

  // ---------------- direction lanes ----------------
  logic signed [15:0] dir_x [NumDir];
  logic signed [15:0] dir_y [NumDir];
  logic signed [15:0] dir_z [NumDir];

  // Substitute the default for an all-zero vector
  always_comb begin
    dir_x[0] = in_data_i.normal_x;
    dir_y[0] = in_data_i.normal_y;
    dir_z[0] = in_data_i.normal_z;
    if (in_data_i.normal_x == '0 && in_data_i.normal_y == '0 &&
        in_data_i.normal_z == '0) begin
      dir_x[0] = '0;
      dir_y[0] = DirNegOne;
      dir_z[0] = '0;
    end
    dir_x[1] = in_data_i.tangent_x;
    dir_y[1] = in_data_i.tangent_y;
    dir_z[1] = in_data_i.tangent_z;
    if (in_data_i.tangent_x == '0 && in_data_i.tangent_y == '0 &&
        in_data_i.tangent_z == '0) begin
      dir_x[1] = DirOne;
      dir_y[1] = '0;
      dir_z[1] = '0;
    end
  end

  logic [15:0]     ax_q  [NumDir];
  logic [15:0]     ay_q  [NumDir];
  logic            xneg_q[NumDir];
  logic            yneg_q[NumDir];
  logic            xpos_q[NumDir];
  logic            ypos_q[NumDir];
  logic            zneg_q[NumDir];
  logic [L1W-1:0]  l1_q  [NumDir];
  logic [DenW-1:0] na_q  [NumDir];
  logic [DenW-1:0] nb_q  [NumDir];
  logic [DenW-1:0] den1_q[NumDir];
  logic [NumW-1:0] numa_q[NumDir];
  logic [NumW-1:0] numb_q[NumDir];
  logic [DenW-1:0] den2_q[NumDir];
  logic [QuoW-1:0] quoa  [NumDir];
  logic [QuoW-1:0] quob  [NumDir];

  logic [15:0]     dax [NumDir];
  logic [15:0]     day [NumDir];
  logic [15:0]     daz [NumDir];
  logic [DenW-1:0] l1x [NumDir];
  logic [DenW-1:0] n_a [NumDir];
  logic [DenW-1:0] n_b [NumDir];

  always_comb begin
    for (int d = 0; d < NumDir; d++) begin
      dax[d] = dir_x[d][15] ? 16'(-dir_x[d]) : dir_x[d];
      day[d] = dir_y[d][15] ? 16'(-dir_y[d]) : dir_y[d];
      daz[d] = dir_z[d][15] ? 16'(-dir_z[d]) : dir_z[d];
      l1x[d] = DenW'(l1_q[d]);
      // Fold the lower hemisphere over the diagonals
      if (zneg_q[d]) begin
        n_a[d] = xpos_q[d] ? DenW'((l1x[d] << 1) - DenW'(ay_q[d])) : DenW'(ay_q[d]);
        n_b[d] = ypos_q[d] ? DenW'((l1x[d] << 1) - DenW'(ax_q[d])) : DenW'(ax_q[d]);
      end else begin
        n_a[d] = xneg_q[d] ? l1x[d] - DenW'(ax_q[d]) : l1x[d] + DenW'(ax_q[d]);
        n_b[d] = yneg_q[d] ? l1x[d] - DenW'(ay_q[d]) : l1x[d] + DenW'(ay_q[d]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < NumDir; d++) begin
      if (stg_en[0]) begin
        ax_q[d]   <= dax[d];
        ay_q[d]   <= day[d];
        xneg_q[d] <= dir_x[d][15];
        yneg_q[d] <= dir_y[d][15];
        xpos_q[d] <= ~dir_x[d][15] && (dir_x[d] != '0);
        ypos_q[d] <= ~dir_y[d][15] && (dir_y[d] != '0);
        zneg_q[d] <= dir_z[d][15];
        l1_q[d]   <= L1W'(dax[d]) + L1W'(day[d]) + L1W'(daz[d]);
      end
      if (stg_en[1]) begin
        na_q[d]   <= n_a[d];
        nb_q[d]   <= n_b[d];
        den1_q[d] <= l1x[d] << 1;
      end
      // Scale numerators by 65535
      if (stg_en[2]) begin
        numa_q[d] <= {na_q[d], 16'h0000} - NumW'(na_q[d]);
        numb_q[d] <= {nb_q[d], 16'h0000} - NumW'(nb_q[d]);
        den2_q[d] <= den1_q[d];
      end
    end
  end

  for (genvar d = 0; d < NumDir; d++) begin : g_dir
    voq_div u_div_a (
      .clk_i (clk_i),
      .en_i  (stg_en[NumStg-1:3]),
      .num_i (numa_q[d]),
      .den_i (den2_q[d]),
      .quo_o (quoa[d])
    );
    voq_div u_div_b (
      .clk_i (clk_i),
      .en_i  (stg_en[NumStg-1:3]),
      .num_i (numb_q[d]),
      .den_i (den2_q[d]),
      .quo_o (quob[d])
    );
  end

  // Carry the handedness bit alongside
  logic sgn_q [NumStg];

  always_ff @(posedge clk_i) begin
    if (stg_en[0]) sgn_q[0] <= in_data_i.tangent_w_positive;
    for (int k = 1; k < NumStg; k++) begin
      if (stg_en[k]) sgn_q[k] <= sgn_q[k-1];
    end
  end

  // Assemble the output beat
  always_comb begin
    out_data_o.qpos_x       = lq_q[DlyN-1][0];
    out_data_o.qpos_y       = lq_q[DlyN-1][1];
    out_data_o.qpos_z       = lq_q[DlyN-1][2];
    out_data_o.qtex_u       = lq_q[DlyN-1][3];
    out_data_o.qtex_v       = lq_q[DlyN-1][4];
    out_data_o.qnormal_a    = quoa[0];
    out_data_o.qnormal_b    = quob[0];
    out_data_o.qtangent_a   = quoa[1];
    out_data_o.qtangent_b   = quob[1];
    out_data_o.tangent_sign = sgn_q[NumStg-1];
  end

endmodule

// ===== rtl/core/voq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voq_assert: port-level checks of the vertex quantizer
// Watches the handshakes and the stall behavior of the pipeline.
// ----------------------------------------------------------------------------
module voq_assert
  import voq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input vtx_out_t out_data_o
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed under stall");

  // An empty output stage never back-pressures the input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage empty");

  // A draining output always lets the pipeline advance
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // Drop all beats under reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output beat shown during reset");

endmodule

bind vertex_octahedral_quantizer voq_assert u_voq_assert (.*);
